// File: sv/dcf77_pulse_frame_decoder_defines.svh
// Assertion macros shared by the pulse frame decoder RTL.
`ifndef DCF77_PULSE_FRAME_DECODER_DEFINES_SVH
`define DCF77_PULSE_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DCF77PFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DCF77PFD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/dcf77pfd_pkg.sv
// Types, constants and helper functions of the pulse frame decoder.
`default_nettype none

package dcf77pfd_pkg;

   // Default number of bits in one minute frame.
   localparam int FRAME_BITS_DEFAULT = 59;

   // Each frame is held in a word of this many bits; frame 1 starts at this offset.
   localparam int FRAME_WORD_BITS = 64;
   localparam int WRITE_POS_W     = $clog2(2 * FRAME_WORD_BITS);

   // Bit positions of the time fields within a frame.
   localparam int MINUTE_LSB = 21;
   localparam int HOUR_LSB   = 29;
   localparam int DAY_LSB    = 36;
   localparam int MONTH_LSB  = 45;
   localparam int YEAR_LSB   = 50;

   // Register reset values.
   localparam logic [15:0] SYNC_LOW_RESET  = 16'd1750;
   localparam logic [15:0] SYNC_HIGH_RESET = 16'd1950;
   localparam logic [15:0] GAP_LOW_RESET   = 16'd750;
   localparam logic [15:0] GAP_HIGH_RESET  = 16'd950;
   localparam logic [15:0] ZERO_LOW_RESET  = 16'd50;
   localparam logic [15:0] SPLIT_RESET     = 16'd150;
   localparam logic [15:0] ONE_HIGH_RESET  = 16'd250;

   typedef enum logic [2:0] {
      CSR_INVERT_POLARITY   = 3'd0,
      CSR_SYNC_LOW_MS       = 3'd1,
      CSR_SYNC_HIGH_MS      = 3'd2,
      CSR_GAP_LOW_MS        = 3'd3,
      CSR_GAP_HIGH_MS       = 3'd4,
      CSR_ZERO_LOW_MS       = 3'd5,
      CSR_ZERO_ONE_SPLIT_MS = 3'd6,
      CSR_ONE_HIGH_MS       = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_TIME_SET     = 2'd1,
      STATUS_TIMING_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic [5:0] hour;
      logic [6:0] minute;
      logic [5:0] day;
      logic [4:0] month;
      logic [7:0] year;
   } stamp_type;

   // Weighted BCD: the low nibble counts 1, 2, 4, 8 and the high nibble 10, 20, 40, 80.
   function automatic logic [7:0] bcd_value(input logic [7:0] raw);
      logic [7:0] tens;
      tens = {1'b0, raw[7:4], 3'b000} + {3'b000, raw[7:4], 1'b0};
      return {4'b0000, raw[3:0]} + tens;
   endfunction

endpackage

`default_nettype wire

// File: sv/dcf77pfd_req_if.sv
// Input channel carrying one edge event per item.
`default_nettype none

interface dcf77pfd_req_if;
   logic        valid;
   logic        ready;
   logic        edge_level;
   logic [15:0] duration_ms;

   modport source (output valid, output edge_level, output duration_ms, input ready);
   modport sink   (input valid, input edge_level, input duration_ms, output ready);
endinterface

`default_nettype wire

// File: sv/dcf77pfd_rsp_if.sv
// Result channel carrying the status and decoded time of one item.
`default_nettype none

interface dcf77pfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [5:0] hour;
   logic [6:0] minute;
   logic [5:0] day;
   logic [4:0] month;
   logic [7:0] year;

   modport source (output valid, output status, output hour, output minute,
                   output day, output month, output year, input ready);
   modport sink   (input valid, input status, input hour, input minute,
                   input day, input month, input year, output ready);
endinterface

`default_nettype wire

// File: sv/dcf77pfd_decode.sv
// Weighted BCD decoder of the time fields of one stored minute frame.
`default_nettype none

module dcf77pfd_decode (
   input  wire logic [dcf77pfd_pkg::FRAME_WORD_BITS-1:0] frame,
   output dcf77pfd_pkg::stamp_type                        stamp
);
   import dcf77pfd_pkg::*;

   logic [7:0] minute_bcd;
   logic [7:0] hour_bcd;
   logic [7:0] day_bcd;
   logic [7:0] month_bcd;
   logic [7:0] year_bcd;

   // Each field keeps only its own bits; unused tens weights read as zero.
   assign minute_bcd = bcd_value({1'b0,   frame[MINUTE_LSB +: 7]});
   assign hour_bcd   = bcd_value({2'b00,  frame[HOUR_LSB   +: 6]});
   assign day_bcd    = bcd_value({2'b00,  frame[DAY_LSB    +: 6]});
   assign month_bcd  = bcd_value({3'b000, frame[MONTH_LSB  +: 5]});
   assign year_bcd   = bcd_value(frame[YEAR_LSB +: 8]);

   assign stamp.minute = minute_bcd[6:0];
   assign stamp.hour   = hour_bcd[5:0];
   assign stamp.day    = day_bcd[5:0];
   assign stamp.month  = month_bcd[4:0];
   assign stamp.year   = year_bcd;

endmodule

`default_nettype wire

// File: sv/dcf77_pulse_frame_decoder.sv
// Top level of the DCF77 pulse frame decoder.
//
// The block takes one edge event per item (the level after the edge and the
// milliseconds since the previous edge) and returns exactly one result item for
// each: status 0 when all is well, 2 on a timing error, and 1 when two
// consecutive minute frames agree one minute apart, in which case the hour,
// minute, day, month and year fields carry the decoded time; otherwise those
// fields are zero. An item is registered on acceptance, worked on by the
// classification, frame storage and decode logic, and placed in the result
// register; one item is taken every clock cycle while the result is taken or
// the result register is free. That rate is set by the single stage of logic
// between the input register and the result register, which also updates the
// frame store and kept time, so each item sees the state that its predecessor
// left. The input side keeps accepting while a finished result waits, and
// stalls only when both registers are full and the result is not taken. The
// timing thresholds and the polarity are written through the csr_ port and
// should be changed only while no item is in flight.
`default_nettype none

`include "dcf77_pulse_frame_decoder_defines.svh"

module dcf77_pulse_frame_decoder #(
   parameter int FRAME_BITS = dcf77pfd_pkg::FRAME_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   dcf77pfd_req_if.sink     req_chan,
   dcf77pfd_rsp_if.source   rsp_chan
);
   import dcf77pfd_pkg::*;

   // The receive count runs up to two full frames.
   localparam int BR_W = $clog2(2 * FRAME_BITS + 1);
   localparam logic [BR_W-1:0] ONE_FRAME  = BR_W'(FRAME_BITS);
   localparam logic [BR_W-1:0] TWO_FRAMES = BR_W'(2 * FRAME_BITS);
   localparam logic [WRITE_POS_W-1:0] FRAME1_START = WRITE_POS_W'(FRAME_WORD_BITS);

   // Configuration registers.
   logic        invert_ff;
   logic [15:0] sync_low_ff, sync_high_ff, gap_low_ff, gap_high_ff;
   logic [15:0] zero_low_ff, split_ff, one_high_ff;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic        in_level_ff;
   logic [15:0] in_duration_ff;

   // Result register.
   logic       out_valid_ff, out_valid_in;
   status_type status_ff, status_in;
   stamp_type  stamp_ff, stamp_in;

   // Receiver state.
   logic [FRAME_WORD_BITS-1:0] frame_ff [2];
   logic [FRAME_WORD_BITS-1:0] frame_in [2];
   logic [BR_W-1:0]        bits_ff, bits_in;
   logic                   sync_seen_ff, sync_seen_in;
   logic [WRITE_POS_W-1:0] wpos_ff, wpos_in;
   stamp_type              kept_ff, kept_in;

   logic      advance;
   stamp_type first_stamp;
   stamp_type second_stamp;

   // The item in the input register moves on whenever the result register is free
   // or is being emptied in the same cycle.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_chan.valid && req_chan.ready) ? 1'b1 :
                         (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   dcf77pfd_decode u_decode_first (
      .frame (frame_ff[0]),
      .stamp (first_stamp)
   );

   dcf77pfd_decode u_decode_second (
      .frame (frame_ff[1]),
      .stamp (second_stamp)
   );

   // Classification of the registered edge, frame storage and minute comparison.
   always_comb begin
      logic                   level;
      logic [BR_W-1:0]        bits_v;
      logic                   sync_v;
      logic [WRITE_POS_W-1:0] wpos_v;
      logic                   is_zero;
      logic                   is_one;
      logic [5:0]             bit_sel;
      logic                   word_sel;
      logic                   next_minute;

      frame_in[0]  = frame_ff[0];
      frame_in[1]  = frame_ff[1];
      bits_in      = bits_ff;
      sync_seen_in = sync_seen_ff;
      wpos_in      = wpos_ff;
      kept_in      = kept_ff;
      status_in    = STATUS_OK;
      stamp_in     = '0;

      level    = in_level_ff ^ invert_ff;
      bits_v   = bits_ff;
      sync_v   = sync_seen_ff;
      wpos_v   = wpos_ff;
      bit_sel  = '0;
      word_sel = 1'b0;
      is_zero  = (in_duration_ff > zero_low_ff) && (in_duration_ff < split_ff);
      is_one   = !is_zero && (in_duration_ff > split_ff) && (in_duration_ff < one_high_ff);
      next_minute = ({1'b0, kept_ff.minute} + 8'd1) == {1'b0, second_stamp.minute};

      if (advance) begin
         if (!level) begin
            // End of a gap: either the minute mark or an ordinary second gap.
            // A gap inside the ordinary window changes nothing.
            if ((in_duration_ff > sync_low_ff) && (in_duration_ff < sync_high_ff)) begin
               sync_seen_in = 1'b1;
               priority if (bits_ff == ONE_FRAME) begin
                  kept_in = first_stamp;
               end else if (bits_ff == TWO_FRAMES) begin
                  if (next_minute && (kept_ff.hour == second_stamp.hour) &&
                      (kept_ff.day == second_stamp.day) &&
                      (kept_ff.month == second_stamp.month) &&
                      (kept_ff.year == second_stamp.year)) begin
                     status_in = STATUS_TIME_SET;
                     stamp_in  = second_stamp;
                  end else begin
                     // No agreement: the newer frame becomes the reference.
                     frame_in[0] = frame_ff[1];
                     bits_in     = ONE_FRAME;
                     kept_in     = second_stamp;
                  end
               end else begin
                  bits_in = '0;
               end
            end else if ((in_duration_ff < gap_low_ff) || (in_duration_ff > gap_high_ff)) begin
               bits_in      = '0;
               sync_seen_in = 1'b0;
               status_in    = STATUS_TIMING_ERROR;
            end
         end else begin
            // End of a data pulse: decide where the bit goes, then store it.
            if (((bits_ff == ONE_FRAME) && !sync_seen_ff) || (bits_ff == TWO_FRAMES)) begin
               bits_v = '0;
               sync_v = 1'b0;
            end else if (bits_ff == ONE_FRAME) begin
               wpos_v = FRAME1_START;
            end
            if (bits_v == '0) begin
               wpos_v = '0;
            end
            wpos_in = wpos_v;

            if (is_zero || is_one) begin
               word_sel = wpos_v[WRITE_POS_W-1];
               bit_sel  = wpos_v[5:0];
               // Entering a new byte clears it, so stale bits never survive.
               if (bit_sel[2:0] == 3'b000) begin
                  frame_in[word_sel] = frame_in[word_sel] &
                                       ~({{(FRAME_WORD_BITS-8){1'b0}}, 8'hFF} << bit_sel);
               end
               if (is_one) begin
                  frame_in[word_sel] = frame_in[word_sel] |
                                       ({{(FRAME_WORD_BITS-1){1'b0}}, 1'b1} << bit_sel);
               end
               wpos_in      = wpos_v + WRITE_POS_W'(1);
               bits_in      = bits_v + BR_W'(1);
               sync_seen_in = sync_v;
            end else begin
               bits_in      = '0;
               sync_seen_in = 1'b0;
               status_in    = STATUS_TIMING_ERROR;
            end
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff    <= 1'b0;
         sync_low_ff  <= SYNC_LOW_RESET;
         sync_high_ff <= SYNC_HIGH_RESET;
         gap_low_ff   <= GAP_LOW_RESET;
         gap_high_ff  <= GAP_HIGH_RESET;
         zero_low_ff  <= ZERO_LOW_RESET;
         split_ff     <= SPLIT_RESET;
         one_high_ff  <= ONE_HIGH_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_INVERT_POLARITY:   invert_ff    <= csr_wdata[0];
            CSR_SYNC_LOW_MS:       sync_low_ff  <= csr_wdata;
            CSR_SYNC_HIGH_MS:      sync_high_ff <= csr_wdata;
            CSR_GAP_LOW_MS:        gap_low_ff   <= csr_wdata;
            CSR_GAP_HIGH_MS:       gap_high_ff  <= csr_wdata;
            CSR_ZERO_LOW_MS:       zero_low_ff  <= csr_wdata;
            CSR_ZERO_ONE_SPLIT_MS: split_ff     <= csr_wdata;
            CSR_ONE_HIGH_MS:       one_high_ff  <= csr_wdata;
         endcase
      end
   end

   // Handshake and receiver state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         frame_ff[0]  <= '0;
         frame_ff[1]  <= '0;
         bits_ff      <= '0;
         sync_seen_ff <= 1'b0;
         wpos_ff      <= '0;
         kept_ff      <= '{hour: 6'd0, minute: 7'd0, day: 6'd1, month: 5'd1, year: 8'd16};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         frame_ff[0]  <= frame_in[0];
         frame_ff[1]  <= frame_in[1];
         bits_ff      <= bits_in;
         sync_seen_ff <= sync_seen_in;
         wpos_ff      <= wpos_in;
         kept_ff      <= kept_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_level_ff    <= req_chan.edge_level;
         in_duration_ff <= req_chan.duration_ms;
      end
      if (advance) begin
         status_ff <= status_in;
         stamp_ff  <= stamp_in;
      end
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.hour   = stamp_ff.hour;
   assign rsp_chan.minute = stamp_ff.minute;
   assign rsp_chan.day    = stamp_ff.day;
   assign rsp_chan.month  = stamp_ff.month;
   assign rsp_chan.year   = stamp_ff.year;

   // A time is only reported one minute after a kept minute, so never at minute zero.
   `DCF77PFD_ASSERT_IMP(a_set_minute_nonzero, clock, reset, out_valid_ff && (status_ff == STATUS_TIME_SET), stamp_ff.minute != 7'd0, "time set with minute zero")
   // The receive count never passes two full frames.
   `DCF77PFD_ASSERT_IMP(a_bits_bounded, clock, reset, 1'b1, bits_ff <= TWO_FRAMES, "receive count beyond two frames")
   // A timing error restarts reception and forgets the minute mark.
   `DCF77PFD_ASSERT_NXT(a_error_restarts, clock, reset, advance && (status_in == STATUS_TIMING_ERROR), (bits_ff == '0) && !sync_seen_ff, "timing error did not restart reception")

endmodule

`default_nettype wire
